/* sv/dstp_pkg.sv */
// Shared types and constants for the dual sensor temperature poller.
`default_nettype none
package dstp_pkg;

  localparam int unsigned CFG_IDX_W  = 2;
  localparam int unsigned CFG_DATA_W = 8;

  // register indexes
  localparam logic [CFG_IDX_W-1:0] CFG_SENSOR_ONE_ADDR = 2'd0;
  localparam logic [CFG_IDX_W-1:0] CFG_SENSOR_TWO_ADDR = 2'd1;
  localparam logic [CFG_IDX_W-1:0] CFG_POINTER_VALUE   = 2'd2;

  localparam logic [6:0] SENSOR_ONE_ADDR_RST = 7'd24;
  localparam logic [6:0] SENSOR_TWO_ADDR_RST = 7'd25;
  localparam logic [7:0] POINTER_VALUE_RST   = 8'd5;

  // two-wire status codes
  localparam logic [7:0] ST_START       = 8'h08;
  localparam logic [7:0] ST_REP_START   = 8'h10;
  localparam logic [7:0] ST_SLA_W_ACK   = 8'h18;
  localparam logic [7:0] ST_SLA_W_NACK  = 8'h20;
  localparam logic [7:0] ST_DATA_W_ACK  = 8'h28;
  localparam logic [7:0] ST_DATA_W_NACK = 8'h30;
  localparam logic [7:0] ST_ARB_LOST    = 8'h38;
  localparam logic [7:0] ST_SLA_R_ACK   = 8'h40;
  localparam logic [7:0] ST_SLA_R_NACK  = 8'h48;
  localparam logic [7:0] ST_DATA_R_ACK  = 8'h50;
  localparam logic [7:0] ST_DATA_R_NACK = 8'h58;

  typedef struct packed {
    logic [7:0] func;
    logic [7:0] rx_byte;
  } in_t;

  typedef struct packed {
    logic       ctl_write;
    logic       ctl_stop;
    logic       ctl_ack;
    logic       ctl_enable;
    logic       tx_valid;
    logic [7:0] tx_byte;
    logic       temp_valid;
    logic       temp_sensor;
    logic [7:0] temp_value;
  } out_t;

endpackage
`default_nettype wire

/* sv/dstp_core.sv */
// Status decode, per-sensor state and configuration registers.
`default_nettype none
module dstp_core (
  input  wire logic                          clk,
  input  wire logic                          rst_n,
  input  wire logic                          cfg_we,
  input  wire logic [dstp_pkg::CFG_IDX_W-1:0]  cfg_idx,
  input  wire logic [dstp_pkg::CFG_DATA_W-1:0] cfg_wdata,
  input  wire logic                          beat,
  input  wire dstp_pkg::in_t                 in_data,
  output dstp_pkg::out_t                     res
);

  logic [6:0] addr_one_r, addr_two_r;
  logic [7:0] pointer_r;
  logic       serving_second_r, serving_second_nxt;
  logic [1:0] ready_r, ready_nxt;
  logic [7:0] high_r [2];
  logic [7:0] high_nxt [2];
  logic       cur;
  logic [6:0] addr;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      addr_one_r <= dstp_pkg::SENSOR_ONE_ADDR_RST;
      addr_two_r <= dstp_pkg::SENSOR_TWO_ADDR_RST;
      pointer_r  <= dstp_pkg::POINTER_VALUE_RST;
    end else if (cfg_we) begin
      unique case (cfg_idx)
        dstp_pkg::CFG_SENSOR_ONE_ADDR: addr_one_r <= cfg_wdata[6:0];
        dstp_pkg::CFG_SENSOR_TWO_ADDR: addr_two_r <= cfg_wdata[6:0];
        dstp_pkg::CFG_POINTER_VALUE:   pointer_r  <= cfg_wdata;
        default: ;
      endcase
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      serving_second_r <= 1'b0;
      ready_r          <= '0;
      high_r[0]        <= '0;
      high_r[1]        <= '0;
    end else if (beat) begin
      serving_second_r <= serving_second_nxt;
      ready_r          <= ready_nxt;
      high_r[0]        <= high_nxt[0];
      high_r[1]        <= high_nxt[1];
    end
  end

  assign cur  = serving_second_r;
  assign addr = cur ? addr_two_r : addr_one_r;

  always_comb begin
    res                = '0;
    res.ctl_write      = 1'b1;
    res.ctl_enable     = 1'b1;
    serving_second_nxt = serving_second_r;
    ready_nxt          = ready_r;
    high_nxt[0]        = high_r[0];
    high_nxt[1]        = high_r[1];
    unique case (in_data.func)
      dstp_pkg::ST_START, dstp_pkg::ST_REP_START: begin
        res.tx_valid = 1'b1;
        res.tx_byte  = {addr, ready_r[cur]};
      end
      dstp_pkg::ST_SLA_W_ACK: begin
        res.tx_valid = 1'b1;
        res.tx_byte  = pointer_r;
      end
      dstp_pkg::ST_SLA_W_NACK: begin
        res.ctl_stop       = 1'b1;
        serving_second_nxt = ~cur;
      end
      dstp_pkg::ST_DATA_W_ACK: begin
        res.ctl_stop       = 1'b1;
        ready_nxt[cur]     = 1'b1;
        serving_second_nxt = ~cur;
      end
      dstp_pkg::ST_DATA_W_NACK: begin
        res.ctl_stop = 1'b1;
      end
      dstp_pkg::ST_ARB_LOST: ;
      dstp_pkg::ST_SLA_R_ACK: begin
        res.ctl_ack = 1'b1;
      end
      dstp_pkg::ST_SLA_R_NACK: begin
        // engine shut off; sensor must be set up again
        res.ctl_stop       = 1'b1;
        res.ctl_enable     = 1'b0;
        ready_nxt[cur]     = 1'b0;
        high_nxt[cur]      = '0;
        serving_second_nxt = ~cur;
      end
      dstp_pkg::ST_DATA_R_ACK: begin
        high_nxt[cur] = in_data.rx_byte;
      end
      dstp_pkg::ST_DATA_R_NACK: begin
        res.ctl_stop       = 1'b1;
        res.temp_valid     = 1'b1;
        res.temp_sensor    = cur;
        res.temp_value     = {high_r[cur][3:0], in_data.rx_byte[7:4]};
        high_nxt[cur]      = '0;
        serving_second_nxt = ~cur;
      end
      default: begin
        res.ctl_write  = 1'b0;
        res.ctl_enable = 1'b0;
      end
    endcase
  end

endmodule
`default_nettype wire

/* sv/dstp_outbuf.sv */
// Result register with a skid stage behind it.
`default_nettype none
module dstp_outbuf (
  input  wire logic           clk,
  input  wire logic           rst_n,
  input  wire logic           in_valid,
  output logic                in_stall,
  input  wire dstp_pkg::out_t in_res,
  output logic                out_valid,
  input  wire logic           out_stall,
  output dstp_pkg::out_t      out_data
);

  logic           out_valid_r, skid_valid_r;
  dstp_pkg::out_t out_data_r, skid_data_r;
  logic           accept, drain;

  assign in_stall = skid_valid_r;
  assign accept   = in_valid & ~skid_valid_r;
  assign drain    = ~out_valid_r | ~out_stall;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_valid_r  <= 1'b0;
      skid_valid_r <= 1'b0;
    end else if (drain) begin
      out_valid_r  <= skid_valid_r | accept;
      skid_valid_r <= 1'b0;
    end else if (accept) begin
      skid_valid_r <= 1'b1;
    end
  end

  always_ff @(posedge clk) begin
    if (drain) begin
      out_data_r <= skid_valid_r ? skid_data_r : in_res;
    end
    if (!drain && accept) begin
      skid_data_r <= in_res;
    end
  end

  assign out_valid = out_valid_r;
  assign out_data  = out_data_r;

endmodule
`default_nettype wire

/* sv/dual_sensor_i2c_temp_poller.sv */
// Dual temperature sensor poller: two-wire status event in, bus command out.
//
// Input channel (in_valid/in_stall/in_data): one beat per two-wire status
// event, holding the status code and the received byte. Result channel
// (out_valid/out_stall/out_data): exactly one beat per input beat, carrying
// the control command, the byte to transmit and any finished temperature.
// The result is registered; one beat per cycle is sustained while out_stall
// is low, set by the single decode stage feeding the result register.
// A two-entry output buffer (result register plus skid) lets the block take
// one more beat while a result waits; in_stall rises only when both are
// full, and stays until the receiver drops out_stall.
// Configuration (cfg_we/cfg_idx/cfg_wdata) writes the two sensor addresses
// and the pointer byte; write only while idle. Index 3 is ignored.
// Synchronous reset restores the default addresses and pointer, serves the
// first sensor, marks both sensors uninitialized and empties the buffer.
`default_nettype none
module dual_sensor_i2c_temp_poller (
  input  wire logic                            clk,
  input  wire logic                            rst_n,
  input  wire logic                            cfg_we,
  input  wire logic [dstp_pkg::CFG_IDX_W-1:0]  cfg_idx,
  input  wire logic [dstp_pkg::CFG_DATA_W-1:0] cfg_wdata,
  input  wire logic                            in_valid,
  output logic                                 in_stall,
  input  wire dstp_pkg::in_t                   in_data,
  output logic                                 out_valid,
  input  wire logic                            out_stall,
  output dstp_pkg::out_t                       out_data
);

  dstp_pkg::out_t res;
  logic           beat;

  assign beat = in_valid & ~in_stall;

  dstp_core u_core (
    .clk       (clk),
    .rst_n     (rst_n),
    .cfg_we    (cfg_we),
    .cfg_idx   (cfg_idx),
    .cfg_wdata (cfg_wdata),
    .beat      (beat),
    .in_data   (in_data),
    .res       (res)
  );

  dstp_outbuf u_outbuf (
    .clk       (clk),
    .rst_n     (rst_n),
    .in_valid  (in_valid),
    .in_stall  (in_stall),
    .in_res    (res),
    .out_valid (out_valid),
    .out_stall (out_stall),
    .out_data  (out_data)
  );

endmodule
`default_nettype wire
